// File: rtl/tfn_pkg.sv
// Package for the triangle face normal unit: widths, types and constants.
// Used by every RTL module in this folder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tfn_pkg;
  localparam int VertexDepth = 1024;
  localparam int AddrW = $clog2(VertexDepth);
  localparam int IdxW = 10;
  localparam int PosW = 16;
  localparam int DiffW = 17;
  localparam int CrossW = 36;
  localparam int MagW = 35;
  localparam int SumW = 72;
  localparam int RootW = 37;
  localparam int DivW = 49;
  localparam int NormW = 16;
  localparam int QDepth = 2;

  // front-to-back job record
  typedef struct packed {
    logic [IdxW-1:0] ca;
    logic [IdxW-1:0] cb;
    logic [IdxW-1:0] cc;
    logic signed [PosW-1:0] p0x, p0y, p0z;
    logic signed [PosW-1:0] p1x, p1y, p1z;
    logic signed [PosW-1:0] p2x, p2y, p2z;
  } job_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_READ,
    FE_PUSH
  } fe_state_t;

  typedef enum logic [3:0] {
    BE_IDLE,
    BE_CROSS,
    BE_SQ,
    BE_ROOT,
    BE_DIV,
    BE_EMIT
  } be_state_t;
endpackage
`default_nettype wire

// File: rtl/tfn_front.sv
// Front end: vertex store, load writes and triangle corner reads.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_front
  import tfn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic              in_kind,
  input  wire logic [IdxW-1:0]   in_vertex_slot,
  input  wire logic [PosW-1:0]   in_pos_x,
  input  wire logic [PosW-1:0]   in_pos_y,
  input  wire logic [PosW-1:0]   in_pos_z,
  input  wire logic [IdxW-1:0]   in_corner_a,
  input  wire logic [IdxW-1:0]   in_corner_b,
  input  wire logic [IdxW-1:0]   in_corner_c,
  output job_t                   job,
  output logic                   job_valid,
  input  wire logic              job_ready
);
  logic [3*PosW-1:0] mem [VertexDepth];
  logic [3*PosW-1:0] rd_r;
  fe_state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] rcnt_r;
  logic rd_ok_r;
  logic [IdxW-1:0] ca_r, cb_r, cc_r;
  logic [3*PosW-1:0] p0_r, p1_r;
  logic accept, tri_acc, ld_acc;
  logic [IdxW-1:0] rd_idx;
  logic [3*PosW-1:0] rd_val;

  assign in_full = (state_r != FE_IDLE);
  assign accept = in_push && !in_full;
  assign ld_acc = accept && !in_kind;
  assign tri_acc = accept && in_kind;

  // corner selected for this read cycle
  always_comb begin
    case (cnt_r)
      2'd0: rd_idx = ca_r;
      2'd1: rd_idx = cb_r;
      default: rd_idx = cc_r;
    endcase
  end

  // store port: one write or one read per cycle
  always_ff @(posedge clk) begin
    if (ld_acc && ({1'b0, in_vertex_slot} < (IdxW+1)'(VertexDepth)))
      mem[in_vertex_slot[AddrW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z};
    if (state_r == FE_READ)
      rd_r <= mem[rd_idx[AddrW-1:0]];
  end

  // out-of-range corners read as zero
  assign rd_val = rd_ok_r ? rd_r : '0;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    case (state_r)
      FE_IDLE: begin
        if (tri_acc) begin
          state_nxt = FE_READ;
          cnt_nxt = 2'd0;
        end
      end
      FE_READ: begin
        if (cnt_r == 2'd2) state_nxt = FE_PUSH;
        else cnt_nxt = cnt_r + 2'd1;
      end
      FE_PUSH: begin
        if (job_ready) state_nxt = FE_IDLE;
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      cnt_r <= '0;
      rcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rcnt_r <= (state_r == FE_READ) ? cnt_r + 2'd1 : 2'd0;
    end
  end

  // capture corners and returned positions
  always_ff @(posedge clk) begin
    if (tri_acc) begin
      ca_r <= in_corner_a;
      cb_r <= in_corner_b;
      cc_r <= in_corner_c;
    end
    rd_ok_r <= ({1'b0, rd_idx} < (IdxW+1)'(VertexDepth));
    if (rcnt_r == 2'd1) p0_r <= rd_val;
    if (rcnt_r == 2'd2) p1_r <= rd_val;
  end

  assign job_valid = (state_r == FE_PUSH);
  always_comb begin
    job.ca = ca_r;
    job.cb = cb_r;
    job.cc = cc_r;
    {job.p0x, job.p0y, job.p0z} = p0_r;
    {job.p1x, job.p1y, job.p1z} = p1_r;
    {job.p2x, job.p2y, job.p2z} = rd_val;
  end
endmodule
`default_nettype wire

// File: rtl/tfn_queue.sv
// Two-entry job queue between front and back ends.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_queue
  import tfn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  job_t      wr_job,
  input  wire logic wr_valid,
  output logic      wr_ready,
  output job_t      rd_job,
  output logic      rd_valid,
  input  wire logic rd_ready
);
  job_t q_r [QDepth];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != 2'(QDepth));
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_job = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// File: rtl/tfn_back.sv
// Back end: cross product, sum of squares, bit-serial square root and
// restoring division, then three results through a one-entry output register.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_back
  import tfn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  job_t                   job,
  input  wire logic              job_valid,
  output logic                   job_ready,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic [IdxW-1:0]        out_target_vertex,
  output logic signed [NormW-1:0] out_norm_x,
  output logic signed [NormW-1:0] out_norm_y,
  output logic signed [NormW-1:0] out_norm_z,
  output logic                   out_degenerate,
  output logic                   out_last_of_run
);
  be_state_t state_r, state_nxt;
  job_t j_r;
  logic [6:0] step_r;
  logic [1:0] comp_r;
  logic [1:0] emit_r;
  logic signed [DiffW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [CrossW-1:0] c_r [3];
  logic [SumW-1:0] sum_r;
  logic [SumW-1:0] rem_r;
  logic [RootW-1:0] root_r;
  logic [DivW-1:0] dq_r;
  logic [RootW:0] drem_r;
  logic [NormW-1:0] n_r [3];
  logic ov_r;
  logic signed [2*DiffW-1:0] m1, m2;
  logic [MagW-1:0] mg;
  logic [2*MagW-1:0] sq;
  logic [SumW+1:0] trial;
  logic [RootW+1:0] dtrial;
  logic [RootW:0] dshift;
  logic signed [CrossW-1:0] csel;
  logic [CrossW-1:0] cmag;
  logic [DivW-1:0] q;

  assign job_ready = (state_r == BE_IDLE);
  assign out_empty = !ov_r;
  assign csel = c_r[comp_r];
  assign cmag = csel[CrossW-1] ? CrossW'(-csel) : CrossW'(csel);

  // one cross component per cycle: shared pair of multipliers
  always_comb begin
    case (comp_r)
      2'd0: begin m1 = ay_r * bz_r; m2 = az_r * by_r; end
      2'd1: begin m1 = az_r * bx_r; m2 = ax_r * bz_r; end
      default: begin m1 = ax_r * by_r; m2 = ay_r * bx_r; end
    endcase
  end
  assign mg = cmag[MagW-1:0];
  assign sq = mg * mg;

  // square root: two bits of remainder per step
  assign trial = {rem_r[SumW-1:0], sum_r[SumW-1 -: 2]} - {root_r, 2'b01};
  // divide: one quotient bit per step
  assign dshift = {drem_r[RootW-1:0], dq_r[DivW-1]};
  assign dtrial = {1'b0, dshift} - {2'b00, root_r};
  assign q = dq_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BE_IDLE:  if (job_valid) state_nxt = BE_CROSS;
      BE_CROSS: if (comp_r == 2'd2) state_nxt = BE_SQ;
      BE_SQ:    if (comp_r == 2'd2) state_nxt = BE_ROOT;
      BE_ROOT:  if (step_r == 7'(SumW/2 - 1)) state_nxt = BE_DIV;
      BE_DIV: begin
        if (root_r == '0) state_nxt = BE_EMIT;
        else if (step_r == 7'(DivW - 1) && comp_r == 2'd2) state_nxt = BE_EMIT;
      end
      BE_EMIT: if (emit_r == 2'd2 && !ov_r) state_nxt = BE_IDLE;
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BE_IDLE;
    else state_r <= state_nxt;
  end

  // magnitude of the first component, used when the root finishes
  function automatic logic [CrossW-1:0] cmag_at0();
    logic signed [CrossW-1:0] v;
    v = c_r[0];
    return v[CrossW-1] ? CrossW'(-v) : CrossW'(v);
  endfunction

  // magnitude of the component after the current one
  function automatic logic [CrossW-1:0] cmag_next();
    logic signed [CrossW-1:0] v;
    v = (comp_r == 2'd0) ? c_r[1] : c_r[2];
    return v[CrossW-1] ? CrossW'(-v) : CrossW'(v);
  endfunction

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      BE_IDLE: begin
        j_r <= job;
        ax_r <= DiffW'(job.p1x) - DiffW'(job.p0x);
        ay_r <= DiffW'(job.p1y) - DiffW'(job.p0y);
        az_r <= DiffW'(job.p1z) - DiffW'(job.p0z);
        bx_r <= DiffW'(job.p2x) - DiffW'(job.p0x);
        by_r <= DiffW'(job.p2y) - DiffW'(job.p0y);
        bz_r <= DiffW'(job.p2z) - DiffW'(job.p0z);
        comp_r <= 2'd0;
        sum_r <= '0;
      end
      BE_CROSS: begin
        c_r[comp_r] <= CrossW'(m1) - CrossW'(m2);
        comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
      end
      BE_SQ: begin
        sum_r <= sum_r + SumW'(sq);
        comp_r <= (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
        step_r <= '0;
        rem_r <= '0;
        root_r <= '0;
      end
      BE_ROOT: begin
        sum_r <= {sum_r[SumW-3:0], 2'b00};
        if (!trial[SumW+1]) begin
          rem_r <= trial[SumW-1:0];
          root_r <= {root_r[RootW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[SumW-3:0], sum_r[SumW-1 -: 2]};
          root_r <= {root_r[RootW-2:0], 1'b0};
        end
        step_r <= (step_r == 7'(SumW/2 - 1)) ? 7'd0 : step_r + 7'd1;
        comp_r <= 2'd0;
        drem_r <= '0;
        dq_r <= DivW'(cmag_at0()) << 14;
      end
      BE_DIV: begin
        if (root_r == '0) begin
          n_r[0] <= '0;
          n_r[1] <= '0;
          n_r[2] <= '0;
        end else if (step_r == 7'(DivW - 1)) begin
          step_r <= '0;
          drem_r <= '0;
          n_r[comp_r] <= csel[CrossW-1] ? NormW'(-{q[DivW-2:0], ~dtrial[RootW+1]})
                                        : NormW'({q[DivW-2:0], ~dtrial[RootW+1]});
          comp_r <= comp_r + 2'd1;
          dq_r <= DivW'(cmag_next()) << 14;
        end else begin
          step_r <= step_r + 7'd1;
          if (!dtrial[RootW+1]) begin
            drem_r <= dtrial[RootW:0];
            dq_r <= {dq_r[DivW-2:0], 1'b1};
          end else begin
            drem_r <= dshift;
            dq_r <= {dq_r[DivW-2:0], 1'b0};
          end
        end
        emit_r <= 2'd0;
      end
      BE_EMIT: begin
        if (!ov_r) emit_r <= emit_r + 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (state_r == BE_EMIT && !ov_r) begin
      ov_r <= 1'b1;
    end else if (out_pop && ov_r) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == BE_EMIT && !ov_r) begin
      case (emit_r)
        2'd0: out_target_vertex <= j_r.ca;
        2'd1: out_target_vertex <= j_r.cb;
        default: out_target_vertex <= j_r.cc;
      endcase
      out_norm_x <= n_r[0];
      out_norm_y <= n_r[1];
      out_norm_z <= n_r[2];
      out_degenerate <= (root_r == '0);
      out_last_of_run <= (emit_r == 2'd2);
    end
  end
endmodule
`default_nettype wire

// File: rtl/triangle_face_normal_unit_top.sv
// Top level of the triangle face normal unit: front end, job queue, back end.
// Depends on tfn_pkg, tfn_front, tfn_queue, tfn_back.
//
//  channel  ports                       handshake
//  input    in_* fields                 in_push / in_full
//  result   out_* fields                out_pop / out_empty
//
// A triangle holds the front for three store reads over one memory port;
// the back end's time on it is set by the bit-serial root and divider, and
// a zero-length face skips the divide.
// Reset is synchronous, active low; the vertex store is not cleared.
// A full queue stalls the front; an unpopped result stalls the back.
`timescale 1ns / 1ps
`default_nettype none
module triangle_face_normal_unit_top
  import tfn_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic                in_kind,
  input  wire logic [IdxW-1:0]     in_vertex_slot,
  input  wire logic signed [PosW-1:0] in_pos_x,
  input  wire logic signed [PosW-1:0] in_pos_y,
  input  wire logic signed [PosW-1:0] in_pos_z,
  input  wire logic [IdxW-1:0]     in_corner_a,
  input  wire logic [IdxW-1:0]     in_corner_b,
  input  wire logic [IdxW-1:0]     in_corner_c,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [IdxW-1:0]          out_target_vertex,
  output logic signed [NormW-1:0]  out_norm_x,
  output logic signed [NormW-1:0]  out_norm_y,
  output logic signed [NormW-1:0]  out_norm_z,
  output logic                     out_degenerate,
  output logic                     out_last_of_run
);
  job_t fj, bj;
  logic fv, fr, bv, br;

  tfn_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_kind, .in_vertex_slot,
    .in_pos_x, .in_pos_y, .in_pos_z, .in_corner_a, .in_corner_b, .in_corner_c,
    .job(fj), .job_valid(fv), .job_ready(fr)
  );

  tfn_queue u_queue (
    .clk, .rst_n, .wr_job(fj), .wr_valid(fv), .wr_ready(fr),
    .rd_job(bj), .rd_valid(bv), .rd_ready(br)
  );

  tfn_back u_back (
    .clk, .rst_n, .job(bj), .job_valid(bv), .job_ready(br),
    .out_empty, .out_pop, .out_target_vertex, .out_norm_x, .out_norm_y,
    .out_norm_z, .out_degenerate, .out_last_of_run
  );
endmodule
`default_nettype wire

// File: rtl/tfn_checker.sv
// Port-level checker for the triangle face normal unit, bound to the top.
// Depends on tfn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tfn_checker
  import tfn_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_push,
  input wire logic in_full,
  input wire logic in_kind,
  input wire logic out_empty,
  input wire logic out_pop,
  input wire logic [NormW-1:0] out_norm_x,
  input wire logic [NormW-1:0] out_norm_y,
  input wire logic [NormW-1:0] out_norm_z,
  input wire logic out_degenerate
);
  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_empty == 1'b0 && !out_pop |=> out_empty == 1'b0)
    else $error("result dropped");
  // degenerate results carry zero normals
  a_deg: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_degenerate |->
      out_norm_x == '0 && out_norm_y == '0 && out_norm_z == '0)
    else $error("degenerate normal not zero");
  // an accepted triangle closes the input for the next cycle
  a_tri: assert property (@(posedge clk) disable iff (!rst_n)
    in_push && !in_full && in_kind |=> in_full)
    else $error("triangle did not stall input");
  // no results right after reset
  a_rst: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result after reset");
endmodule

bind triangle_face_normal_unit_top tfn_checker u_tfn_checker (
  .clk, .rst_n, .in_push, .in_full, .in_kind, .out_empty, .out_pop,
  .out_norm_x, .out_norm_y, .out_norm_z, .out_degenerate
);
`default_nettype wire

// File: tb/triangle_face_normal_unit_top_tb.sv
// Testbench for triangle_face_normal_unit_top: loads vertex positions, sends triangles and
// checks every corner result against a built-in face normal predictor.
// Depends on tfn_pkg and the RTL of the unit.
`timescale 1ns / 1ps
module triangle_face_normal_unit_top_tb;
  import tfn_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int DrainCycles = 400;

  typedef struct packed {
    logic [IdxW-1:0] vtx;
    logic signed [NormW-1:0] nx, ny, nz;
    logic degen;
    logic last;
  } corner_normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  logic in_kind = 1'b0;
  logic [IdxW-1:0] in_vertex_slot = '0;
  logic signed [PosW-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [IdxW-1:0] in_corner_a = '0, in_corner_b = '0, in_corner_c = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [IdxW-1:0] out_target_vertex;
  logic signed [NormW-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic out_degenerate, out_last_of_run;

  // predictor state: vertex store and which entries were written
  logic signed [PosW-1:0] vert_x [VertexDepth];
  logic signed [PosW-1:0] vert_y [VertexDepth];
  logic signed [PosW-1:0] vert_z [VertexDepth];
  bit vert_valid [VertexDepth];
  int loaded_slots [$];

  corner_normal_t pending_normals [$];
  int error_count = 0;
  int idle_cycles = 0;
  bit pop_enable = 1'b1;

  triangle_face_normal_unit_top i_dut (.*);

  always #5 clk = ~clk;

  // mismatch report
  task automatic report_mismatch(input string what);
    error_count++;
    $display("mismatch: %s", what);
  endtask

  function automatic logic [63:0] isqrt(input logic [71:0] s);
    logic [79:0] lo, hi, m;
    lo = 0;
    hi = 80'd1 << 37;
    while (hi - lo > 1) begin
      m = lo + (hi - lo) / 2;
      if (m * m <= {8'd0, s}) lo = m;
      else hi = m;
    end
    return lo[63:0];
  endfunction

  function automatic logic signed [NormW-1:0] scale_normal(input longint c,
                                                           input longint len);
    longint q;
    q = ((c < 0 ? -c : c) <<< 14) / len;
    if (c < 0) q = -q;
    return q[NormW-1:0];
  endfunction

  // face normal prediction for one triangle
  task automatic predict_face(input logic [IdxW-1:0] ia, ib, ic);
    longint p [3][3];
    longint ax, ay, az, bx, by, bz, cx, cy, cz, len;
    logic [71:0] sum;
    logic [IdxW-1:0] ids [3];
    corner_normal_t r;
    ids[0] = ia; ids[1] = ib; ids[2] = ic;
    for (int k = 0; k < 3; k++) begin
      p[k][0] = vert_x[ids[k]];
      p[k][1] = vert_y[ids[k]];
      p[k][2] = vert_z[ids[k]];
    end
    ax = p[1][0] - p[0][0]; ay = p[1][1] - p[0][1]; az = p[1][2] - p[0][2];
    bx = p[2][0] - p[0][0]; by = p[2][1] - p[0][1]; bz = p[2][2] - p[0][2];
    cx = ay * bz - az * by;
    cy = az * bx - ax * bz;
    cz = ax * by - ay * bx;
    sum = 72'(72'(cx) * 72'(cx)) + 72'(72'(cy) * 72'(cy)) + 72'(72'(cz) * 72'(cz));
    len = longint'(isqrt(sum));
    for (int k = 0; k < 3; k++) begin
      r.vtx = ids[k];
      r.degen = (len == 0);
      r.nx = r.degen ? '0 : scale_normal(cx, len);
      r.ny = r.degen ? '0 : scale_normal(cy, len);
      r.nz = r.degen ? '0 : scale_normal(cz, len);
      r.last = (k == 2);
      pending_normals.push_back(r);
    end
  endtask

  function automatic int gap_length();
    int n;
    n = $urandom_range(0, 99);
    if (n < 50) n = 0;
    else if (n < 93) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    return n;
  endfunction

  // one input transaction; prediction happens at acceptance
  task automatic send_item(input bit kind, input logic [IdxW-1:0] slot,
                           input logic [PosW-1:0] x, y, z,
                           input logic [IdxW-1:0] a, b, c);
    int gap;
    in_push <= 1'b1;
    in_kind <= kind;
    in_vertex_slot <= slot;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    in_corner_a <= a; in_corner_b <= b; in_corner_c <= c;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (kind == 1'b0) begin
      vert_x[slot] = x; vert_y[slot] = y; vert_z[slot] = z;
      if (!vert_valid[slot]) loaded_slots.push_back(int'(slot));
      vert_valid[slot] = 1'b1;
    end else begin
      predict_face(a, b, c);
    end
    gap = ($urandom_range(0, 2) != 0) ? gap_length() : 0;
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_vertex(input logic [IdxW-1:0] slot, input logic [PosW-1:0] x, y, z);
    send_item(1'b0, slot, x, y, z, IdxW'($urandom), IdxW'($urandom), IdxW'($urandom));
  endtask

  task automatic send_face(input logic [IdxW-1:0] a, b, c);
    send_item(1'b1, IdxW'($urandom), PosW'($urandom), PosW'($urandom), PosW'($urandom),
              a, b, c);
  endtask

  function automatic logic [IdxW-1:0] pick_loaded();
    return IdxW'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]);
  endfunction

  task automatic wait_results_drained();
    in_push <= 1'b0;
    while (pending_normals.size() != 0) @(posedge clk);
  endtask

  // extremes of positions, index ends, repeated corners, zero-length faces
  task automatic test_directed();
    load_vertex(10'd0, 16'sh8000, 16'sh8000, 16'sh8000);
    load_vertex(10'd1023, 16'sh7fff, 16'sh8000, 16'sh8000);
    load_vertex(10'd512, 16'sh8000, 16'sh7fff, 16'sh8000);
    load_vertex(10'd3, 16'sh8000, 16'sh8000, 16'sh7fff);
    load_vertex(10'd4, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    load_vertex(10'd5, 16'sh0000, 16'sh0000, 16'sh0000);
    load_vertex(10'd6, 16'sh4000, 16'sh0000, 16'sh0000);
    load_vertex(10'd7, 16'sh0000, 16'sh4000, 16'sh0000);
    load_vertex(10'd8, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_face(10'd0, 10'd1023, 10'd512);
    send_face(10'd0, 10'd512, 10'd1023);
    send_face(10'd0, 10'd1023, 10'd3);
    send_face(10'd1023, 10'd512, 10'd3);
    send_face(10'd5, 10'd6, 10'd7);
    send_face(10'd4, 10'd4, 10'd4);
    send_face(10'd0, 10'd0, 10'd1023);
    send_face(10'd4, 10'd8, 10'd0);
    send_face(10'd4, 10'd0, 10'd8);
    load_vertex(10'd5, 16'sh1234, 16'shedcb, 16'sh0001);
    send_face(10'd5, 10'd6, 10'd7);
    send_face(10'd1023, 10'd4, 10'd0);
  endtask

  // mostly faces over loaded vertices, some reloads
  task automatic test_random_mesh(input int count);
    for (int i = 0; i < count; i++) begin
      if (loaded_slots.size() < 6 || $urandom_range(0, 3) == 0)
        load_vertex(IdxW'($urandom), PosW'($urandom), PosW'($urandom), PosW'($urandom));
      else if ($urandom_range(0, 15) == 0)
        send_face(pick_loaded(), pick_loaded(), IdxW'(loaded_slots[0]));
      else
        send_face(pick_loaded(), pick_loaded(), pick_loaded());
    end
  endtask

  // sender holds off until every expected result has come
  task automatic test_drain_pause();
    send_face(pick_loaded(), pick_loaded(), pick_loaded());
    wait_results_drained();
    send_face(pick_loaded(), pick_loaded(), pick_loaded());
  endtask

  // result side: random pops and checking against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      corner_normal_t e;
      if (pending_normals.size() == 0) begin
        report_mismatch($sformatf("unexpected result vertex %0d", out_target_vertex));
      end else begin
        e = pending_normals.pop_front();
        if (out_target_vertex !== e.vtx)
          report_mismatch($sformatf("target_vertex %0d exp %0d", out_target_vertex, e.vtx));
        if (out_norm_x !== e.nx)
          report_mismatch($sformatf("norm_x %0d exp %0d", out_norm_x, e.nx));
        if (out_norm_y !== e.ny)
          report_mismatch($sformatf("norm_y %0d exp %0d", out_norm_y, e.ny));
        if (out_norm_z !== e.nz)
          report_mismatch($sformatf("norm_z %0d exp %0d", out_norm_z, e.nz));
        if (out_degenerate !== e.degen)
          report_mismatch($sformatf("degenerate %0b exp %0b", out_degenerate, e.degen));
        if (out_last_of_run !== e.last)
          report_mismatch($sformatf("last_of_run %0b exp %0b", out_last_of_run, e.last));
      end
    end
    if (!pop_enable) out_pop <= 1'b0;
    else if ($urandom_range(0, 99) < 8) out_pop <= 1'b0;
    else if ($urandom_range(0, 99) < 2) out_pop <= 1'b0;
    else out_pop <= ($urandom_range(0, 3) != 0) || out_pop;
  end

  // occasional long receiver stall
  initial begin
    forever begin
      repeat ($urandom_range(200, 2000)) @(posedge clk);
      pop_enable <= 1'b0;
      repeat ($urandom_range(5, 80)) @(posedge clk);
      pop_enable <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("triangle_face_normal_unit_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mesh(200);
    test_drain_pause();
    test_random_mesh(240);
    wait_results_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending_normals.size() == 0)
      $display("triangle_face_normal_unit_top_tb OK");
    else
      $display("triangle_face_normal_unit_top_tb NOT OK");
    $finish;
  end
endmodule
